// File: rtl/core/uje_pkg.sv
// shared types, codes and helpers for the utf-8 json string escaper
package uje_pkg;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic [20:0] CP_MIN_2BYTE = 21'h00080;
	localparam logic [20:0] CP_MIN_3BYTE = 21'h00800;
	localparam logic [20:0] CP_MIN_4BYTE = 21'h10000;
	localparam logic [20:0] CP_MAX       = 21'h10ffff;
	localparam logic [20:0] CP_SURR_LO   = 21'h0d800;
	localparam logic [20:0] CP_SURR_HI   = 21'h0dfff;
	localparam logic [20:0] CP_BMP_MAX   = 21'h0ffff;
	localparam logic [15:0] SURR_HIGH    = 16'hd800;
	localparam logic [15:0] SURR_LOW     = 16'hdc00;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_U         = 8'h75;
	localparam logic [7:0] CH_DEL       = 8'h7f;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_ACTIVE = 2'd1,
		MODE_FAILED = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		CMD_CHAR = 3'd0,
		CMD_ESC  = 3'd1,
		CMD_UNIT = 3'd2,
		CMD_PAIR = 3'd3,
		CMD_ERR  = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       error;
		logic       last;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  ch;
		logic [15:0] unit0;
		logic [15:0] unit1;
	} cmd_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} queue_status_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] res;
		if (nib < 4'd10) begin
			res = 8'h30 + {4'd0, nib};
		end else begin
			res = 8'h57 + {4'd0, nib};
		end
		return res;
	endfunction

	function automatic logic [3:0] last_step(input cmd_kind_t kind);
		logic [3:0] res;
		unique case (kind)
			CMD_ESC:  res = 4'd1;
			CMD_UNIT: res = 4'd5;
			CMD_PAIR: res = 4'd11;
			default:  res = 4'd0;
		endcase
		return res;
	endfunction

endpackage

// File: rtl/core/uje_front.sv
// front end: utf-8 decoder and classifier; each item yields at most one command
module uje_front import uje_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t req,
	output logic     push,
	output cmd_t     cmd
);

	mode_t       mode_q, mode_n;
	logic [1:0]  rem_q, rem_n;
	logic [1:0]  len_q, len_n;
	logic [20:0] acc_q, acc_n;
	logic        has_cmd;
	logic [7:0]  b;
	logic [20:0] acc_shift;
	logic [1:0]  rem_dec;
	logic [20:0] cp_min;
	logic [20:0] cp_off;

	assign b         = req.in_byte;
	assign acc_shift = {acc_q[14:0], b[5:0]};
	assign rem_dec   = rem_q - 2'd1;
	assign cp_off    = acc_shift - CP_MIN_4BYTE;

	always_comb begin
		unique case (len_q)
			2'd1:    cp_min = CP_MIN_2BYTE;
			2'd2:    cp_min = CP_MIN_3BYTE;
			default: cp_min = CP_MIN_4BYTE;
		endcase
	end

	always_comb begin
		mode_n    = mode_q;
		rem_n     = rem_q;
		len_n     = len_q;
		acc_n     = acc_q;
		has_cmd   = 1'b0;
		cmd.kind  = CMD_CHAR;
		cmd.ch    = CH_QUOTE;
		cmd.unit0 = {8'd0, b};
		cmd.unit1 = 16'd0;
		unique case (req.op)
			OP_START: begin
				mode_n  = MODE_ACTIVE;
				rem_n   = 2'd0;
				len_n   = 2'd0;
				acc_n   = 21'd0;
				has_cmd = 1'b1;
			end
			OP_DATA: begin
				if (mode_q == MODE_ACTIVE) begin
					if (rem_q != 2'd0) begin
						if (b[7:6] != 2'b10) begin
							has_cmd  = 1'b1;
							cmd.kind = CMD_ERR;
							mode_n   = MODE_FAILED;
							rem_n    = 2'd0;
							len_n    = 2'd0;
							acc_n    = 21'd0;
						end else if (rem_dec != 2'd0) begin
							acc_n = acc_shift;
							rem_n = rem_dec;
						end else begin
							// sequence complete: range checks then emit
							has_cmd = 1'b1;
							rem_n   = 2'd0;
							len_n   = 2'd0;
							acc_n   = 21'd0;
							if (acc_shift < cp_min || acc_shift > CP_MAX
									|| (acc_shift >= CP_SURR_LO && acc_shift <= CP_SURR_HI)) begin
								cmd.kind = CMD_ERR;
								mode_n   = MODE_FAILED;
							end else if (acc_shift <= CP_BMP_MAX) begin
								cmd.kind  = CMD_UNIT;
								cmd.unit0 = acc_shift[15:0];
							end else begin
								cmd.kind  = CMD_PAIR;
								cmd.unit0 = SURR_HIGH | {6'd0, cp_off[19:10]};
								cmd.unit1 = SURR_LOW | {6'd0, cp_off[9:0]};
							end
						end
					end else if (b[7] == 1'b0) begin
						has_cmd = 1'b1;
						unique case (b)
							8'h22: begin cmd.kind = CMD_ESC; cmd.ch = CH_QUOTE; end
							8'h5c: begin cmd.kind = CMD_ESC; cmd.ch = CH_BACKSLASH; end
							8'h08: begin cmd.kind = CMD_ESC; cmd.ch = 8'h62; end
							8'h0c: begin cmd.kind = CMD_ESC; cmd.ch = 8'h66; end
							8'h0a: begin cmd.kind = CMD_ESC; cmd.ch = 8'h6e; end
							8'h0d: begin cmd.kind = CMD_ESC; cmd.ch = 8'h72; end
							8'h09: begin cmd.kind = CMD_ESC; cmd.ch = 8'h74; end
							default: begin
								if (b < CH_SPACE || b == CH_DEL) begin
									cmd.kind = CMD_UNIT;
								end else begin
									cmd.kind = CMD_CHAR;
									cmd.ch   = b;
								end
							end
						endcase
					end else if (b >= 8'hc2 && b <= 8'hdf) begin
						acc_n = {16'd0, b[4:0]};
						len_n = 2'd1;
						rem_n = 2'd1;
					end else if (b >= 8'he0 && b <= 8'hef) begin
						acc_n = {17'd0, b[3:0]};
						len_n = 2'd2;
						rem_n = 2'd2;
					end else if (b >= 8'hf0 && b <= 8'hf4) begin
						acc_n = {18'd0, b[2:0]};
						len_n = 2'd3;
						rem_n = 2'd3;
					end else begin
						has_cmd  = 1'b1;
						cmd.kind = CMD_ERR;
						mode_n   = MODE_FAILED;
						rem_n    = 2'd0;
						len_n    = 2'd0;
						acc_n    = 21'd0;
					end
				end
			end
			OP_END: begin
				if (mode_q == MODE_ACTIVE) begin
					has_cmd = 1'b1;
					mode_n  = MODE_IDLE;
					if (rem_q != 2'd0) begin
						cmd.kind = CMD_ERR;
						rem_n    = 2'd0;
						len_n    = 2'd0;
						acc_n    = 21'd0;
					end
				end
			end
			default: begin
				has_cmd = 1'b0;
			end
		endcase
	end

	assign push = accept && has_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			rem_q  <= 2'd0;
			len_q  <= 2'd0;
			acc_q  <= 21'd0;
		end else if (accept) begin
			mode_q <= mode_n;
			rem_q  <= rem_n;
			len_q  <= len_n;
			acc_q  <= acc_n;
		end
	end

endmodule

// File: rtl/core/uje_queue.sv
// short command queue between the decoder and the character sequencer
module uje_queue import uje_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          push_data,
	input  logic          pop,
	output cmd_t          head,
	output queue_status_t status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] res;
		if (p == PTR_W'(DEPTH - 1)) begin
			res = '0;
		end else begin
			res = p + PTR_W'(1);
		end
		return res;
	endfunction

	assign head             = slots_q[rd_ptr_q];
	assign status.not_empty = (count_q != '0);
	assign status.full      = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/uje_back.sv
// back end: expands commands to the output register, one char per cycle unless stalled
module uje_back import uje_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          head,
	input  queue_status_t status,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output out_item_t     rsp
);

	cmd_t        cmd_q;
	logic        busy_q;
	logic [3:0]  step_q;
	out_item_t   out_q;
	logic        out_valid_q;

	logic        load_out;
	logic        final_step;
	logic        sel_hi;
	logic [3:0]  sub;
	logic [15:0] unit;
	out_item_t   gen;

	assign load_out   = busy_q && (!out_valid_q || rsp_ready);
	assign final_step = (step_q == last_step(cmd_q.kind));
	assign pop        = status.not_empty && (!busy_q || (load_out && final_step));

	assign sel_hi = (step_q >= 4'd6);
	assign sub    = sel_hi ? step_q - 4'd6 : step_q;
	assign unit   = sel_hi ? cmd_q.unit1 : cmd_q.unit0;

	always_comb begin
		gen.error = 1'b0;
		gen.last  = final_step;
		unique case (cmd_q.kind)
			CMD_CHAR: gen.out_char = cmd_q.ch;
			CMD_ESC:  gen.out_char = (step_q == 4'd0) ? CH_BACKSLASH : cmd_q.ch;
			CMD_UNIT, CMD_PAIR: begin
				unique case (sub)
					4'd0:    gen.out_char = CH_BACKSLASH;
					4'd1:    gen.out_char = CH_U;
					4'd2:    gen.out_char = hex_char(unit[15:12]);
					4'd3:    gen.out_char = hex_char(unit[11:8]);
					4'd4:    gen.out_char = hex_char(unit[7:4]);
					default: gen.out_char = hex_char(unit[3:0]);
				endcase
			end
			default: begin
				gen.out_char = 8'd0;
				gen.error    = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (load_out) begin
			out_q <= gen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= 4'd0;
			end else if (load_out) begin
				if (final_step) begin
					busy_q <= 1'b0;
					step_q <= 4'd0;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// an error result is always the only and final result of its item
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.error |-> out_q.last && out_q.out_char == 8'd0)
		else $error("error result not marked last");

	// the sequencer never runs past the end of its command
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= last_step(cmd_q.kind))
		else $error("sequencer step out of range");

	// a surrogate pair starts with a high surrogate and ends with a low one
	a_pair_units: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cmd_q.kind == CMD_PAIR |->
			cmd_q.unit0[15:10] == 6'b110110 && cmd_q.unit1[15:10] == 6'b110111)
		else $error("malformed surrogate pair");

	// a new command is only taken when the previous one has been fully emitted
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop && busy_q |-> load_out && final_step)
		else $error("command replaced before completion");

endmodule

// File: rtl/core/utf8_json_string_escaper.sv
// top level of the utf-8 to json string escaper
// Usage:
//   req channel (req_valid/req_ready, payload req): one item per framing
//   event or byte; op start opens a string, op data carries a byte, op end
//   closes it. rsp channel (rsp_valid/rsp_ready, payload rsp): one escaped
//   ascii character per item, with last set on the final character that an
//   input item causes and error set on the single result of a bad string.
//   The first character that an item causes passes through a queue slot,
//   the sequencer's command register and the output register; the output
//   side then delivers one character per cycle while rsp_ready is high, so
//   a byte that becomes one character sustains one item per cycle. Escapes
//   give 2, \uXXXX 6, a surrogate pair 12 characters, which sets the rate.
//   Items with no result (data while no string is open) enter no queue slot.
//   A command queue of QUEUE_DEPTH entries sits between decoder and
//   sequencer; req_ready drops only when it is full, so a stalled receiver
//   backs up first into the output register, then the queue, then req.
//   Reset clears the decoder to idle, empties the queue and drops rsp_valid.
module utf8_json_string_escaper import uje_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	logic          accept;
	logic          push;
	logic          pop;
	cmd_t          push_cmd;
	cmd_t          head;
	queue_status_t status;

	assign req_ready = !status.full;
	assign accept    = req_valid && req_ready;

	uje_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.push   (push),
		.cmd    (push_cmd)
	);

	uje_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	uje_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (status),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
